// ===== rtl/core/bale_pkg.sv =====
package bale_pkg;

    localparam int FIELD_W = 5;

    localparam logic [3:0] OP_INS_FRONT  = 4'd0;
    localparam logic [3:0] OP_INS_BACK   = 4'd1;
    localparam logic [3:0] OP_INS_AT     = 4'd2;
    localparam logic [3:0] OP_REM_FRONT  = 4'd3;
    localparam logic [3:0] OP_REM_BACK   = 4'd4;
    localparam logic [3:0] OP_REM_AT     = 4'd5;
    localparam logic [3:0] OP_FIND       = 4'd6;
    localparam logic [3:0] OP_COUNT_LESS = 4'd7;
    localparam logic [3:0] OP_SORT_UP    = 4'd8;
    localparam logic [3:0] OP_SORT_DOWN  = 4'd9;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_RANGE = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_EX,
        S_REM_RD,
        S_REM_EX,
        S_SCAN_RD,
        S_SCAN_EX,
        S_SORT_LD_RD,
        S_SORT_LD_EX,
        S_SORT_RD,
        S_SORT_EX,
        S_DONE
    } state_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] found_position;
        logic [FIELD_W-1:0] less_count;
        logic [FIELD_W-1:0] list_size;
        logic               is_full;
        logic               is_empty;
    } res_t;

endpackage

// ===== rtl/core/bale_store.sv =====
module bale_store
    import bale_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/bale_cmp.sv =====
module bale_cmp
    import bale_pkg::*;
(
    input  logic [31:0] a,
    input  logic [31:0] b,
    output cmp_res_t    res
);

    always_comb
    begin
        res.lt = $signed(a) < $signed(b);
        res.eq = a == b;
    end

endmodule

// ===== rtl/core/bale_ctrl.sv =====
module bale_ctrl
    import bale_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         operation,
    input  logic [31:0]        value,
    input  logic [FIELD_W-1:0] position,
    output logic               res_valid,
    input  logic               res_ready,
    output res_t               res
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > FIELD_W) ? CW : FIELD_W;
    localparam int MW = XW + 1;

    state_t      state_reg, state_next;
    logic [3:0]  op_reg, op_next;
    logic [31:0] value_reg, value_next;
    logic [31:0] held_reg, held_next;
    logic [1:0]  status_reg, status_next;
    logic [XW-1:0] acc_reg, acc_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] stop_reg, stop_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;

    logic [31:0] cmp_b;
    cmp_res_t    cmp;

    logic          accept;
    logic          list_full;
    logic          list_empty;
    logic [MW-1:0] count_x;
    logic [MW-1:0] pos_x;
    logic [MW-1:0] pos_m1;
    logic          ins_bad_pos;
    logic          rem_bad_pos;
    logic [CW-1:0] idx_p1;
    logic [CW-1:0] idx_m1;
    logic [XW-1:0] count_w;
    logic          swap;

    bale_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bale_cmp u_cmp (
        .a   (mem_rdata),
        .b   (cmp_b),
        .res (cmp)
    );

    assign in_ready    = state_reg == S_IDLE;
    assign accept      = in_valid && in_ready;
    assign res_valid   = state_reg == S_DONE;
    assign list_full   = count_reg == CW'(CAPACITY);
    assign list_empty  = count_reg == '0;
    assign count_x     = MW'(count_reg);
    assign pos_x       = MW'(position);
    assign pos_m1      = pos_x - MW'(1);
    assign ins_bad_pos = (pos_x == '0) || (pos_x > count_x + MW'(1));
    assign rem_bad_pos = (pos_x == '0) || (pos_x > count_x);
    assign idx_p1      = idx_reg + CW'(1);
    assign idx_m1      = idx_reg - CW'(1);
    assign count_w     = XW'(count_reg);
    assign cmp_b       = (state_reg == S_SORT_EX) ? held_reg : value_reg;
    // mem_rdata is the right-hand entry, held_reg the left-hand one
    assign swap        = (op_reg == OP_SORT_UP) ? cmp.lt : (!cmp.lt && !cmp.eq);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        OP_INS_FRONT, OP_INS_BACK:
                            state_next = list_full ? S_DONE : S_INS_RD;
                        OP_INS_AT:
                            state_next = (list_full || ins_bad_pos) ? S_DONE : S_INS_RD;
                        OP_REM_FRONT:
                            state_next = list_empty ? S_DONE : S_REM_RD;
                        OP_REM_AT:
                            state_next = (list_empty || rem_bad_pos) ? S_DONE : S_REM_RD;
                        OP_FIND, OP_COUNT_LESS:
                            state_next = S_SCAN_RD;
                        OP_SORT_UP, OP_SORT_DOWN:
                            state_next = (count_reg <= CW'(1)) ? S_DONE : S_SORT_LD_RD;
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_INS_RD:
                state_next = (idx_reg == stop_reg) ? S_DONE : S_INS_EX;
            S_INS_EX:
                state_next = S_INS_RD;
            S_REM_RD:
                state_next = (idx_p1 >= count_reg) ? S_DONE : S_REM_EX;
            S_REM_EX:
                state_next = S_REM_RD;
            S_SCAN_RD:
                state_next = (idx_reg == count_reg) ? S_DONE : S_SCAN_EX;
            S_SCAN_EX:
                state_next = (op_reg == OP_FIND && cmp.eq) ? S_DONE : S_SCAN_RD;
            S_SORT_LD_RD:
                state_next = S_SORT_LD_EX;
            S_SORT_LD_EX:
                state_next = S_SORT_RD;
            S_SORT_RD:
            begin
                if (idx_reg == stop_reg)
                begin
                    state_next = (stop_reg == CW'(1)) ? S_DONE : S_SORT_LD_RD;
                end
                else
                begin
                    state_next = S_SORT_EX;
                end
            end
            S_SORT_EX:
                state_next = S_SORT_RD;
            S_DONE:
                state_next = res_ready ? S_IDLE : S_DONE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op_next     = op_reg;
        value_next  = value_reg;
        held_next   = held_reg;
        status_next = status_reg;
        acc_next    = acc_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        stop_next   = stop_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg[AW-1:0];
        mem_wdata   = mem_rdata;
        mem_raddr   = idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = operation;
                    value_next  = value;
                    status_next = STAT_OK;
                    acc_next    = '0;
                    idx_next    = '0;
                    stop_next   = '0;
                    case (operation)
                        OP_INS_FRONT, OP_INS_BACK, OP_INS_AT:
                        begin
                            // shift from the top down to the insertion slot
                            idx_next = count_reg;
                            if (operation == OP_INS_BACK)
                            begin
                                stop_next = count_reg;
                            end
                            else if (operation == OP_INS_AT)
                            begin
                                stop_next = pos_m1[CW-1:0];
                            end
                            if (list_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else if (operation == OP_INS_AT && ins_bad_pos)
                            begin
                                status_next = STAT_RANGE;
                            end
                        end
                        OP_REM_FRONT, OP_REM_BACK, OP_REM_AT:
                        begin
                            if (operation == OP_REM_AT)
                            begin
                                idx_next = pos_m1[CW-1:0];
                            end
                            if (list_empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else if (operation == OP_REM_AT && rem_bad_pos)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else if (operation == OP_REM_BACK)
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_SORT_UP, OP_SORT_DOWN:
                        begin
                            stop_next = count_reg - CW'(1);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                mem_raddr = idx_m1[AW-1:0];
                if (idx_reg == stop_reg)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = stop_reg[AW-1:0];
                    mem_wdata  = value_reg;
                    count_next = count_reg + CW'(1);
                end
            end
            S_INS_EX:
            begin
                mem_we   = 1'b1;
                idx_next = idx_m1;
            end
            S_REM_RD:
            begin
                mem_raddr = idx_p1[AW-1:0];
                if (idx_p1 >= count_reg)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            S_REM_EX:
            begin
                mem_we   = 1'b1;
                idx_next = idx_p1;
            end
            S_SCAN_EX:
            begin
                if (op_reg == OP_FIND)
                begin
                    if (cmp.eq)
                    begin
                        acc_next = XW'(idx_reg) + XW'(1);
                    end
                end
                else if (cmp.lt)
                begin
                    acc_next = acc_reg + XW'(1);
                end
                idx_next = idx_p1;
            end
            S_SORT_LD_RD:
            begin
                mem_raddr = '0;
                idx_next  = '0;
            end
            S_SORT_LD_EX:
            begin
                held_next = mem_rdata;
            end
            S_SORT_RD:
            begin
                mem_raddr = idx_p1[AW-1:0];
                if (idx_reg == stop_reg)
                begin
                    // park the bubbled extreme at the end of this pass
                    mem_we    = 1'b1;
                    mem_wdata = held_reg;
                    stop_next = stop_reg - CW'(1);
                end
            end
            S_SORT_EX:
            begin
                mem_we    = 1'b1;
                mem_wdata = swap ? mem_rdata : held_reg;
                held_next = swap ? held_reg : mem_rdata;
                idx_next  = idx_p1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res.status         = status_reg;
        res.found_position = (op_reg == OP_FIND) ? acc_reg[FIELD_W-1:0] : '0;
        res.less_count     = (op_reg == OP_COUNT_LESS) ? acc_reg[FIELD_W-1:0] : '0;
        res.list_size      = count_w[FIELD_W-1:0];
        res.is_full        = list_full;
        res.is_empty       = list_empty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            stop_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            stop_reg  <= stop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        value_reg  <= value_next;
        held_reg   <= held_next;
        status_reg <= status_next;
        acc_reg    <= acc_next;
    end

endmodule

// ===== rtl/core/bounded_array_list_engine.sv =====
// Status-only, remove-back and rejected items go straight to the result; insert and
// remove step through each shifted entry; find and count scan the entries, find
// stopping at the first match; sort runs bubble passes when two or more entries are held.
// The next item is taken only after the result of the last one has left the
// sequencer, in the cycle after it leaves.
// Reset (rst_n low, asynchronous) empties the list; entry storage is not cleared.
module bounded_array_list_engine
    import bale_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value[31:0], position[36:32], zero fill
    input  logic [3:0]  s_axis_tuser,   // operation[3:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // status[1:0], found_position[6:2],
                                        // less_count[11:7], list_size[16:12],
                                        // is_full[17], is_empty[18], zero fill
);

    logic  res_valid;
    logic  res_ready;
    res_t  res;
    logic        out_valid_reg, out_valid_next;
    logic [23:0] out_data_reg, out_data_next;

    bale_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .operation (s_axis_tuser),
        .value     (s_axis_tdata[31:0]),
        .position  (s_axis_tdata[36:32]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_data_next = {5'b0, res.is_empty, res.is_full, res.list_size,
                                 res.less_count, res.found_position, res.status};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_full_empty_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[17] && m_axis_tdata[18]))
        else $error("list reported full and empty together");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] == STAT_FULL) |-> m_axis_tdata[17])
        else $error("full status without full flag");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] == STAT_EMPTY) |-> m_axis_tdata[18])
        else $error("empty status without empty flag");

    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !res_valid)
        else $error("sequencer ready while a result is pending");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("pending result changed before it was taken");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import bale_pkg::*;

    localparam int CAP          = 16;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 400;

    localparam logic [3:0]        OP_FIRST_UNUSED = OP_SORT_DOWN + 4'd1;
    localparam logic [3:0]        OP_LAST_UNUSED  = 4'hF;
    localparam logic signed [31:0] VAL_MIN        = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX        = 32'sh7FFF_FFFF;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [39:0] s_data  = '0;      // value[31:0], position[36:32], zero fill
    logic [3:0]  s_user  = '0;      // operation[3:0]
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [23:0] m_data;            // status[1:0], found_position[6:2],
                                    // less_count[11:7], list_size[16:12],
                                    // is_full[17], is_empty[18], zero fill

    logic signed [31:0] list_mirror[$];
    res_t               expected_replies[$];

    int errors          = 0;
    int items_sent      = 0;
    int replies_checked = 0;
    int full_rejects    = 0;
    int empty_rejects   = 0;
    int range_rejects   = 0;
    int sink_hold       = 0;
    int idle_cycles     = 0;
    bit idle_off        = 1'b0;

    bounded_array_list_engine #(
        .CAPACITY(CAP)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_valid),
        .s_axis_tready(s_ready),
        .s_axis_tdata (s_data),
        .s_axis_tuser (s_user),
        .m_axis_tvalid(m_valid),
        .m_axis_tready(m_ready),
        .m_axis_tdata (m_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (idle_off)
            return 0;
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mirror of the list: apply one operation and return the reply it earns.
    function automatic res_t apply_list_op(input logic [3:0] op,
                                           input logic signed [31:0] val,
                                           input logic [4:0] pos);
        res_t              r;
        int                n;
        bit                hit;
        bit                swap;
        logic signed [31:0] tmp;
        r   = '0;
        hit = 1'b0;
        n   = list_mirror.size();
        case (op)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT:
            begin
                if (n >= CAP)
                    r.status = STAT_FULL;
                else if (op == OP_INS_FRONT)
                    list_mirror.push_front(val);
                else if (op == OP_INS_BACK)
                    list_mirror.push_back(val);
                else if (pos < 1 || pos > n + 1)
                    r.status = STAT_RANGE;
                else
                    list_mirror.insert(pos - 1, val);
            end
            OP_REM_FRONT, OP_REM_BACK, OP_REM_AT:
            begin
                if (n == 0)
                    r.status = STAT_EMPTY;
                else if (op == OP_REM_FRONT)
                    list_mirror.delete(0);
                else if (op == OP_REM_BACK)
                    list_mirror.delete(n - 1);
                else if (pos < 1 || pos > n)
                    r.status = STAT_RANGE;
                else
                    list_mirror.delete(pos - 1);
            end
            OP_FIND:
            begin
                for (int i = 0; i < n; i++)
                begin
                    if (!hit && list_mirror[i] == val)
                    begin
                        r.found_position = 5'(i + 1);
                        hit = 1'b1;
                    end
                end
            end
            OP_COUNT_LESS:
            begin
                for (int i = 0; i < n; i++)
                begin
                    if (list_mirror[i] < val)
                        r.less_count = r.less_count + 1'b1;
                end
            end
            OP_SORT_UP, OP_SORT_DOWN:
            begin
                for (int i = 0; i + 1 < n; i++)
                begin
                    for (int j = 0; j + 1 < n - i; j++)
                    begin
                        if (op == OP_SORT_DOWN)
                            swap = list_mirror[j] < list_mirror[j + 1];
                        else
                            swap = list_mirror[j + 1] < list_mirror[j];
                        if (swap)
                        begin
                            tmp                = list_mirror[j];
                            list_mirror[j]     = list_mirror[j + 1];
                            list_mirror[j + 1] = tmp;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        n           = list_mirror.size();
        r.list_size = 5'(n);
        r.is_full   = (n == CAP);
        r.is_empty  = (n == 0);
        if (r.status == STAT_FULL)
            full_rejects++;
        if (r.status == STAT_EMPTY)
            empty_rejects++;
        if (r.status == STAT_RANGE)
            range_rejects++;
        return r;
    endfunction

    function automatic logic signed [31:0] rand_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            case ($urandom_range(0, 3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        // reuse held values so that find hits and sorts see ties
        if (roll < 40 && list_mirror.size() > 0)
            return list_mirror[$urandom_range(0, list_mirror.size() - 1)];
        if (roll < 55)
            return $urandom_range(0, 15) - 8;
        return $urandom();
    endfunction

    task automatic send_item(input logic [3:0] op, input logic signed [31:0] val,
                             input logic [4:0] pos);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            s_valid <= 1'b0;
        end
        @(negedge clk);
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= {3'b000, pos, val};
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
        expected_replies.push_back(apply_list_op(op, val, pos));
        items_sent++;
    endtask

    task automatic idle_source();
        @(negedge clk);
        s_valid <= 1'b0;
    endtask

    task automatic random_item(input int ins_pct, input int rem_pct);
        int         roll;
        int         n;
        logic [3:0] op;
        logic [4:0] pos;
        roll = $urandom_range(0, 99);
        n    = list_mirror.size();
        if (roll < ins_pct)
            op = 4'($urandom_range(OP_INS_FRONT, OP_INS_AT));
        else if (roll < ins_pct + rem_pct)
            op = 4'($urandom_range(OP_REM_FRONT, OP_REM_AT));
        else if (roll < 97)
            op = 4'($urandom_range(OP_FIND, OP_SORT_DOWN));
        else
            op = 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
        if ($urandom_range(0, 9) == 0)
            pos = 5'($urandom());
        else
            pos = 5'($urandom_range(1, n + 1));
        send_item(op, rand_value(), pos);
    endtask

    task automatic test_empty_list();
        send_item(OP_REM_FRONT, 32'sd0, 5'd1);
        send_item(OP_REM_AT, 32'sd0, 5'd1);        // empty beats range
        send_item(OP_COUNT_LESS, VAL_MAX, 5'd0);
        send_item(OP_INS_AT, 32'sd3, 5'd2);        // only position 1 is legal
    endtask

    task automatic test_fill_to_capacity();
        send_item(OP_INS_AT, 32'sd7, 5'd1);
        send_item(OP_INS_BACK, VAL_MAX, 5'd0);
        send_item(OP_INS_FRONT, VAL_MIN, 5'd0);
        send_item(OP_INS_AT, -32'sd1, 5'd4);       // count+1 appends
        send_item(OP_INS_AT, 32'sd0, 5'd2);
        for (int k = 0; k < 11; k++)
        begin
            case (k % 3)
                0:       send_item(OP_INS_FRONT, 32'sh5555_5555 ^ k, 5'd0);
                1:       send_item(OP_INS_BACK, 32'shAAAA_AAAA ^ k, 5'd0);
                default: send_item(OP_INS_AT, k - 5, 5'(k % 4 + 1));
            endcase
        end
        send_item(OP_INS_AT, 32'sd5, 5'd31);       // full beats range
        send_item(OP_FIND, -32'sd1, 5'd0);
        send_item(OP_COUNT_LESS, 32'sd0, 5'd0);
        send_item(OP_SORT_UP, 32'sd0, 5'd0);
        send_item(OP_SORT_DOWN, 32'sd0, 5'd0);
        send_item(OP_REM_AT, 32'sd0, 5'd17);
        send_item(OP_REM_AT, 32'sd0, 5'd0);
        send_item(OP_FIRST_UNUSED, 32'sd0, 5'd0);
        send_item(OP_LAST_UNUSED, 32'sd0, 5'd0);
        send_item(OP_REM_AT, 32'sd0, 5'd16);
    endtask

    task automatic test_random_mix(input int count);
        repeat (count)
            random_item(35, 30);
    endtask

    // swing the size between empty and full a few times
    task automatic test_size_sweeps(input int rounds);
        repeat (rounds)
        begin
            repeat (40)
                random_item(80, 5);
            repeat (40)
                random_item(5, 80);
        end
    endtask

    task automatic test_back_to_back(input int count);
        idle_off = 1'b1;
        repeat (count)
            random_item(40, 35);
        idle_off = 1'b0;
    endtask

    task automatic test_drain_pause(input int rounds);
        repeat (rounds)
        begin
            repeat (5)
                random_item(45, 30);
            idle_source();
            while (expected_replies.size() != 0)
                @(posedge clk);
        end
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(negedge clk)
    begin
        if (sink_hold > 0)
        begin
            sink_hold <= sink_hold - 1;
            m_ready   <= 1'b0;
        end
        else
        begin
            m_ready   <= 1'b1;
            sink_hold <= pick_gap();
        end
    end

    always @(posedge clk)
    begin : reply_check
        res_t got;
        res_t want;
        if (rst_n && m_valid && m_ready)
        begin
            got.status         = m_data[1:0];
            got.found_position = m_data[6:2];
            got.less_count     = m_data[11:7];
            got.list_size      = m_data[16:12];
            got.is_full        = m_data[17];
            got.is_empty       = m_data[18];
            if (expected_replies.size() == 0)
            begin
                $error("reply beat with nothing outstanding");
                errors++;
            end
            else
            begin
                want = expected_replies.pop_front();
                check_field("status", int'(want.status), int'(got.status));
                check_field("found_position", int'(want.found_position),
                            int'(got.found_position));
                check_field("less_count", int'(want.less_count), int'(got.less_count));
                check_field("list_size", int'(want.list_size), int'(got.list_size));
                check_field("is_full", int'(want.is_full), int'(got.is_full));
                check_field("is_empty", int'(want.is_empty), int'(got.is_empty));
            end
            replies_checked++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("bounded_array_list_engine regression: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_fill_to_capacity();
        test_random_mix(70);
        test_size_sweeps(3);
        test_back_to_back(40);
        test_drain_pause(4);

        idle_source();
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Sent %0d items, checked %0d replies over all ten operations and unused codes.",
                 items_sent, replies_checked);
        $display("Rejects seen: %0d full, %0d empty, %0d position out of range.",
                 full_rejects, empty_rejects, range_rejects);
        if (errors == 0 && expected_replies.size() == 0)
            $display("bounded_array_list_engine regression: pass");
        else
            $display("bounded_array_list_engine regression: fail");
        $finish;
    end

endmodule
